// ===== hdl/ilps_pkg.sv =====
package ilps_pkg;

	// default cap on how many elements one string may store
	localparam int unsigned MAX_ELEMENTS_BOUND_DEF = 256;

	localparam int unsigned COUNT_W = 9;
	localparam int unsigned COUNT_MAX = 511;

	// configuration register indexes
	localparam logic [1:0] REG_SIZE   = 2'd0;
	localparam logic [1:0] REG_SIGNED = 2'd1;
	localparam logic [1:0] REG_MAX    = 2'd2;

	// element size codes
	localparam logic [2:0] SZ_BYTE  = 3'd0;
	localparam logic [2:0] SZ_HALF  = 3'd1;
	localparam logic [2:0] SZ_WORD  = 3'd2;
	localparam logic [2:0] SZ_DWORD = 3'd3;

	// number bases
	localparam logic [4:0] BASE_OCT = 5'd8;
	localparam logic [4:0] BASE_DEC = 5'd10;
	localparam logic [4:0] BASE_HEX = 5'd16;
	localparam logic [4:0] DIGIT_NONE = 5'd31;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_UC_G  = 8'h47;
	localparam logic [7:0] CH_UC_K  = 8'h4b;
	localparam logic [7:0] CH_UC_M  = 8'h4d;
	localparam logic [7:0] CH_UC_T  = 8'h54;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_G  = 8'h67;
	localparam logic [7:0] CH_LC_K  = 8'h6b;
	localparam logic [7:0] CH_LC_M  = 8'h6d;
	localparam logic [7:0] CH_LC_T  = 8'h74;
	localparam logic [7:0] CH_LC_X  = 8'h78;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_NODIG  = 3'd1,
		ERR_SUFFIX = 3'd2,
		ERR_NEG    = 3'd3,
		ERR_SHIFT  = 3'd4,
		ERR_MANY   = 3'd5,
		ERR_RANGE  = 3'd6,
		ERR_SIZE   = 3'd7
	} err_t;

	typedef enum logic [6:0] {
		PH_START  = 7'b0000001,
		PH_SEP    = 7'b0000010,
		PH_LEADWS = 7'b0000100,
		PH_SIGN   = 7'b0001000,
		PH_ZERO   = 7'b0010000,
		PH_XPFX   = 7'b0100000,
		PH_DIGITS = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [2:0]         size_code;
		logic               signed_allowed;
		logic [COUNT_W-1:0] max_elements;
	} cfg_t;

	typedef struct packed {
		logic [63:0] acc;
		logic        minus;
		logic        ovf;
	} num_state_t;

	typedef struct packed {
		err_t        err;
		logic [63:0] value;
	} end_res_t;

	function automatic logic [4:0] digit_val(input logic [7:0] c);
		logic [4:0] d;
		d = DIGIT_NONE;
		if (c >= CH_0 && c <= CH_9) begin
			d = 5'(c - CH_0);
		end else if (c >= CH_LC_A && c <= CH_LC_F) begin
			d = 5'(c - CH_LC_A) + 5'd10;
		end else if (c >= CH_UC_A && c <= CH_UC_F) begin
			d = 5'(c - CH_UC_A) + 5'd10;
		end
		return d;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);
	endfunction

endpackage

// ===== hdl/ilps_number_end.sv =====
module ilps_number_end (
	input  ilps_pkg::num_state_t            num,
	input  logic [7:0]                      character,
	input  ilps_pkg::cfg_t                  cfg,
	input  logic [ilps_pkg::COUNT_W-1:0]    count,
	input  logic [ilps_pkg::COUNT_W-1:0]    limit,
	output ilps_pkg::end_res_t              res
);
	import ilps_pkg::*;

	logic [63:0] v;
	logic [63:0] sh;
	logic        neg_bad;
	logic        sfx_bad;
	logic        shift_bad;
	logic        range_bad;
	logic        size_bad;

	always_comb begin
		v = num.ovf ? '1 : (num.minus ? (64'd0 - num.acc) : num.acc);
		neg_bad = v[63] && !cfg.signed_allowed;

		// suffix picks the shift; the dropped bits must all equal the sign
		sfx_bad = 1'b0;
		shift_bad = 1'b0;
		sh = v;
		case (character) inside
			CH_LC_T, CH_UC_T: begin
				sh = v << 40;
				shift_bad = !((&v[63:23]) || (~|v[63:23]));
			end
			CH_LC_G, CH_UC_G: begin
				sh = v << 30;
				shift_bad = !((&v[63:33]) || (~|v[63:33]));
			end
			CH_LC_M, CH_UC_M: begin
				sh = v << 20;
				shift_bad = !((&v[63:43]) || (~|v[63:43]));
			end
			CH_LC_K, CH_UC_K: begin
				sh = v << 10;
				shift_bad = !((&v[63:53]) || (~|v[63:53]));
			end
			CH_SPACE, CH_TAB, CH_COMMA, CH_NUL: begin
				sh = v;
			end
			default: begin
				sfx_bad = 1'b1;
			end
		endcase

		range_bad = 1'b0;
		size_bad = 1'b0;
		unique case (cfg.size_code)
			SZ_BYTE: begin
				range_bad = cfg.signed_allowed ? !((&sh[63:7]) || (~|sh[63:7]))
					: (|sh[63:8]);
			end
			SZ_HALF: begin
				range_bad = cfg.signed_allowed ? !((&sh[63:15]) || (~|sh[63:15]))
					: (|sh[63:16]);
			end
			SZ_WORD: begin
				range_bad = cfg.signed_allowed ? !((&sh[63:31]) || (~|sh[63:31]))
					: (|sh[63:32]);
			end
			SZ_DWORD: begin
				range_bad = 1'b0;
			end
			default: begin
				size_bad = 1'b1;
			end
		endcase

		res.value = sh;
		if (neg_bad) begin
			res.err = ERR_NEG;
		end else if (sfx_bad) begin
			res.err = ERR_SUFFIX;
		end else if (shift_bad) begin
			res.err = ERR_SHIFT;
		end else if (count >= limit) begin
			res.err = ERR_MANY;
		end else if (size_bad) begin
			res.err = ERR_SIZE;
		end else if (range_bad) begin
			res.err = ERR_RANGE;
		end else begin
			res.err = ERR_NONE;
		end
	end

endmodule

// ===== hdl/integer_list_parser_suffix_core.sv =====
// Parses a NUL-terminated text, one character word per cycle, into a list of
// integers (strtoul-style base detection: 0x hex, leading 0 octal, else decimal;
// optional sign, leading white space, k/m/g/t suffix shifting by 10/20/30/40,
// separators space, tab or comma). The block takes one character every cycle
// as long as result_ready keeps the output register draining: a character goes
// into an input register, is parsed against the parse state in that cycle and
// its result word, if any, lands in an output register. A character yields a
// result word when it completes an element and always on the terminating NUL
// (finished set, with success, count and error code; element and finish share
// one word when the NUL ends a number). The first error stops parsing until
// the NUL, after which parsing restarts with count and error cleared.
// Configuration (size code, signed enable, element limit) is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. It keeps its value across
// strings; the element limit is capped at MAX_ELEMENTS_BOUND and COUNT_MAX.
module integer_list_parser_suffix_core #(
	parameter int unsigned MAX_ELEMENTS_BOUND = ilps_pkg::MAX_ELEMENTS_BOUND_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [ilps_pkg::COUNT_W-1:0] cfg_data,
	// character channel
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [7:0]                   character,
	// result channel
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic signed [63:0]           element_value,
	output logic                         element_valid,
	output logic                         finished,
	output logic                         success,
	output logic [ilps_pkg::COUNT_W-1:0] element_count,
	output logic [2:0]                   error_code
);
	import ilps_pkg::*;

	// cap usable with a 9-bit limit register
	localparam int unsigned LimitCap =
		(MAX_ELEMENTS_BOUND > COUNT_MAX) ? COUNT_MAX : MAX_ELEMENTS_BOUND;

	// configuration
	cfg_t               cfg_q;
	logic [COUNT_W-1:0] limit;

	// input stage
	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               advance;

	// parse state
	phase_t             phase_q;
	num_state_t         num_q;
	logic [4:0]         base_q;
	logic [COUNT_W-1:0] count_q;
	err_t               err_q;

	// next state
	phase_t             n_phase;
	num_state_t         n_num;
	logic [4:0]         n_base;
	logic [COUNT_W-1:0] n_count;
	err_t               n_err;
	logic               elem_valid;
	logic               start_num;
	logic               begin_dig;
	logic               dig_or_end;
	logic               fin;

	// digit accumulate
	logic [4:0]         dv;
	logic [68:0]        acc_scaled;
	logic [68:0]        acc_sum;
	logic               acc_ovf;

	end_res_t           end_res;

	// result register
	logic               result_valid_q;
	logic [63:0]        value_q;
	logic               elem_valid_q;
	logic               fin_q;
	logic               success_q;
	logic [COUNT_W-1:0] count_out_q;
	err_t               err_out_q;

	// configuration registers, reset to byte size 4, unsigned, 256 elements
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_code      <= SZ_WORD;
			cfg_q.signed_allowed <= 1'b0;
			cfg_q.max_elements   <= COUNT_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE:   cfg_q.size_code      <= cfg_data[2:0];
				REG_SIGNED: cfg_q.signed_allowed <= cfg_data[0];
				REG_MAX:    cfg_q.max_elements   <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign limit = (cfg_q.max_elements > COUNT_W'(LimitCap)) ? COUNT_W'(LimitCap)
		: cfg_q.max_elements;

	// a character is parsed once the output register has room for its result
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			char_s1 <= character;
		end
	end

	// acc * base + digit, 69 bits wide so a carry past bit 63 flags overflow
	always_comb begin
		dv = digit_val(char_s1);
		case (base_q)
			BASE_OCT: acc_scaled = {2'b00, num_q.acc, 3'b000};
			BASE_HEX: acc_scaled = {1'b0, num_q.acc, 4'b0000};
			default:  acc_scaled = {2'b00, num_q.acc, 3'b000} + {4'b0000, num_q.acc, 1'b0};
		endcase
		acc_sum = acc_scaled + 69'(dv);
		acc_ovf = |acc_sum[68:64];
	end

	// checks and suffix shift for the number that this character ends
	ilps_number_end u_number_end (
		.num       (num_q),
		.character (char_s1),
		.cfg       (cfg_q),
		.count     (count_q),
		.limit     (limit),
		.res       (end_res)
	);

	// one parse step
	always_comb begin
		n_phase    = phase_q;
		n_num      = num_q;
		n_base     = base_q;
		n_count    = count_q;
		n_err      = err_q;
		elem_valid = 1'b0;
		start_num  = 1'b0;
		begin_dig  = 1'b0;
		dig_or_end = 1'b0;
		fin        = (char_s1 == CH_NUL);

		if (err_q == ERR_NONE) begin
			unique case (phase_q)
				PH_START, PH_SEP: begin
					// separators only count between numbers
					if (!fin && !(phase_q == PH_SEP && is_sep(char_s1))) begin
						if (is_ws(char_s1)) begin
							n_phase = PH_LEADWS;
						end else begin
							start_num = 1'b1;
						end
					end
				end
				PH_LEADWS: begin
					if (!is_ws(char_s1)) begin
						start_num = 1'b1;
					end
				end
				PH_SIGN: begin
					if (is_dec(char_s1)) begin
						begin_dig = 1'b1;
					end else begin
						n_err = ERR_NODIG;
					end
				end
				PH_XPFX: begin
					// 0x with no hex digit ends the number at the x
					if (dv < BASE_HEX) begin
						n_num.acc = 64'(dv);
						n_base    = BASE_HEX;
						n_phase   = PH_DIGITS;
					end else begin
						n_phase = PH_SEP;
						n_err   = ERR_SUFFIX;
					end
				end
				PH_ZERO: begin
					if (char_s1 == CH_LC_X || char_s1 == CH_UC_X) begin
						n_phase = PH_XPFX;
					end else begin
						dig_or_end = 1'b1;
					end
				end
				PH_DIGITS: begin
					dig_or_end = 1'b1;
				end
				default: begin
					n_phase = PH_START;
				end
			endcase

			if (start_num) begin
				n_num.minus = 1'b0;
				n_num.ovf   = 1'b0;
				if (char_s1 == CH_PLUS) begin
					n_phase = PH_SIGN;
				end else if (char_s1 == CH_MINUS) begin
					n_num.minus = 1'b1;
					n_phase     = PH_SIGN;
				end else if (is_dec(char_s1)) begin
					begin_dig = 1'b1;
				end else begin
					n_err = ERR_NODIG;
				end
			end

			if (begin_dig) begin
				n_num.ovf = 1'b0;
				if (char_s1 == CH_0) begin
					n_num.acc = '0;
					n_base    = BASE_OCT;
					n_phase   = PH_ZERO;
				end else begin
					n_num.acc = 64'(char_s1 - CH_0);
					n_base    = BASE_DEC;
					n_phase   = PH_DIGITS;
				end
			end

			if (dig_or_end) begin
				if (dv < base_q) begin
					// once overflowed the value clamps to all ones
					if (!num_q.ovf) begin
						if (acc_ovf) begin
							n_num.ovf = 1'b1;
						end else begin
							n_num.acc = acc_sum[63:0];
						end
					end
					n_phase = PH_DIGITS;
				end else begin
					n_phase = PH_SEP;
					n_err   = end_res.err;
					if (end_res.err == ERR_NONE) begin
						elem_valid = 1'b1;
						n_count    = count_q + COUNT_W'(1);
					end
				end
			end
		end
	end

	// parse state, restarted after the NUL
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			num_q   <= '0;
			base_q  <= BASE_DEC;
			count_q <= '0;
			err_q   <= ERR_NONE;
		end else if (advance) begin
			if (fin) begin
				phase_q <= PH_START;
				num_q   <= '0;
				base_q  <= BASE_DEC;
				count_q <= '0;
				err_q   <= ERR_NONE;
			end else begin
				phase_q <= n_phase;
				num_q   <= n_num;
				base_q  <= n_base;
				count_q <= n_count;
				err_q   <= n_err;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && (fin || elem_valid)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (fin || elem_valid)) begin
			value_q      <= elem_valid ? end_res.value : '0;
			elem_valid_q <= elem_valid;
			fin_q        <= fin;
			success_q    <= fin && (n_err == ERR_NONE) && (n_count != '0);
			count_out_q  <= n_count;
			err_out_q    <= fin ? n_err : ERR_NONE;
		end
	end

	assign result_valid  = result_valid_q;
	assign element_value = value_q;
	assign element_valid = elem_valid_q;
	assign finished      = fin_q;
	assign success       = success_q;
	assign element_count = count_out_q;
	assign error_code    = err_out_q;

	// stored count never passes the active limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= limit) || $past(cfg_we))
		else $error("element count above limit");

	// a latched error blocks any further element
	a_no_elem_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |-> !elem_valid)
		else $error("element produced after error");

	// the NUL restarts parsing with count and error cleared
	a_finish_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fin) |=> (count_q == '0 && err_q == ERR_NONE && phase_q == PH_START))
		else $error("parse state not restarted after end of string");

	// a stored element always leaves a nonzero count
	a_elem_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && elem_valid_q) |-> (count_out_q != '0))
		else $error("element word with zero count");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ilps_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	// idle tail after the last result word is taken
	localparam int unsigned TAIL_CYCLES = 8;

	// one word on the result side
	typedef struct {
		logic [63:0]        value;
		logic               elem;
		logic               fin;
		logic               ok;
		logic [COUNT_W-1:0] count;
		logic [2:0]         code;
	} result_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = REG_SIZE;
	logic [COUNT_W-1:0] cfg_data = '0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [7:0]         character = CH_NUL;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [63:0] element_value;
	logic               element_valid;
	logic               finished;
	logic               success;
	logic [COUNT_W-1:0] element_count;
	logic [2:0]         error_code;

	integer_list_parser_suffix_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.character    (character),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.element_value(element_value),
		.element_valid(element_valid),
		.finished     (finished),
		.success      (success),
		.element_count(element_count),
		.error_code   (error_code)
	);

	always #6 clk = ~clk;

	// text bytes waiting for the driver, and words the parser owes us
	logic [7:0]   pending_chars[$];
	result_word_t parsed_words[$];
	int unsigned  chars_queued = 0;
	int unsigned  chars_accepted = 0;
	int unsigned  faults = 0;
	int unsigned  cycles = 0;

	// shadow copy of the configuration registers
	logic [2:0]         cfg_size;
	logic               cfg_signed;
	logic [COUNT_W-1:0] cfg_max;

	// shadow copy of the parse state
	phase_t             m_phase;
	logic [63:0]        m_acc;
	logic [4:0]         m_base;
	logic               m_minus;
	logic               m_ovf;
	logic [COUNT_W-1:0] m_count;
	err_t               m_err;

	// ---------------------------------------------------------------
	// parse predictor
	// ---------------------------------------------------------------

	// hex digit value of a byte, 99 when it is no digit at all
	function automatic logic [63:0] char_digit(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return 64'(c - CH_0);
		if (c >= CH_LC_A && c <= CH_LC_F) return 64'(c - CH_LC_A) + 64'd10;
		if (c >= CH_UC_A && c <= CH_UC_F) return 64'(c - CH_UC_A) + 64'd10;
		return 64'd99;
	endfunction

	// space plus tab through carriage return
	function automatic logic white_char(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic fits_width(input logic [63:0] v, input int unsigned bits);
		logic [63:0] half;
		half = 64'd1 << (bits - 1);
		if (cfg_signed) return (v + half) < (half << 1);
		return v < (half << 1);
	endfunction

	task automatic restart_parse();
		m_phase = PH_START;
		m_acc = '0;
		m_base = BASE_DEC;
		m_minus = 1'b0;
		m_ovf = 1'b0;
		m_count = '0;
		m_err = ERR_NONE;
	endtask

	task automatic begin_digits(input logic [7:0] c);
		m_ovf = 1'b0;
		if (c == CH_0) begin
			// a leading zero means octal unless an x follows
			m_acc = '0;
			m_base = BASE_OCT;
			m_phase = PH_ZERO;
		end else begin
			m_acc = 64'(c - CH_0);
			m_base = BASE_DEC;
			m_phase = PH_DIGITS;
		end
	endtask

	task automatic start_number(input logic [7:0] c);
		m_minus = 1'b0;
		m_ovf = 1'b0;
		if (c == CH_PLUS) begin
			m_phase = PH_SIGN;
		end else if (c == CH_MINUS) begin
			m_minus = 1'b1;
			m_phase = PH_SIGN;
		end else if (c >= CH_0 && c <= CH_9) begin
			begin_digits(c);
		end else begin
			m_err = ERR_NODIG;
		end
	endtask

	// number ends at byte c: checks in order negative, suffix, shift, count, then range or size
	task automatic close_number(input logic [7:0] c, output logic stored,
			output logic [63:0] val);
		logic [63:0] v, sh, back;
		int unsigned shift, limit;
		stored = 1'b0;
		val = '0;
		v = m_ovf ? '1 : (m_minus ? 64'd0 - m_acc : m_acc);
		m_phase = PH_SEP;
		if (v[63] && !cfg_signed) begin
			m_err = ERR_NEG;
			return;
		end
		case (c)
			CH_LC_T, CH_UC_T: shift = 40;
			CH_LC_G, CH_UC_G: shift = 30;
			CH_LC_M, CH_UC_M: shift = 20;
			CH_LC_K, CH_UC_K: shift = 10;
			CH_SPACE, CH_TAB, CH_COMMA, CH_NUL: shift = 0;
			default: begin
				m_err = ERR_SUFFIX;
				return;
			end
		endcase
		// shift must be undone by an arithmetic shift back
		sh = v << shift;
		back = sh >> shift;
		if (sh[63]) back = back | ~({64{1'b1}} >> shift);
		if (back != v) begin
			m_err = ERR_SHIFT;
			return;
		end
		limit = (cfg_max > MAX_ELEMENTS_BOUND_DEF) ? MAX_ELEMENTS_BOUND_DEF : cfg_max;
		if (m_count >= limit) begin
			m_err = ERR_MANY;
			return;
		end
		case (cfg_size)
			SZ_BYTE: if (!fits_width(sh, 8)) m_err = ERR_RANGE;
			SZ_HALF: if (!fits_width(sh, 16)) m_err = ERR_RANGE;
			SZ_WORD: if (!fits_width(sh, 32)) m_err = ERR_RANGE;
			SZ_DWORD: ;
			default: m_err = ERR_SIZE;
		endcase
		if (m_err != ERR_NONE) return;
		m_count = m_count + 1'b1;
		val = sh;
		stored = 1'b1;
	endtask

	task automatic digit_or_close(input logic [7:0] c, output logic stored,
			output logic [63:0] val);
		logic [63:0] d;
		d = char_digit(c);
		stored = 1'b0;
		val = '0;
		if (d < 64'(m_base)) begin
			// strtoul style: once it overflows the value sticks at all ones
			if (!m_ovf) begin
				if (m_acc > ({64{1'b1}} - d) / 64'(m_base))
					m_ovf = 1'b1;
				else
					m_acc = m_acc * 64'(m_base) + d;
			end
			m_phase = PH_DIGITS;
		end else begin
			close_number(c, stored, val);
		end
	endtask

	// advance the shadow parser by one accepted byte and log any word it owes
	task automatic parse_char(input logic [7:0] c);
		logic         stored;
		logic [63:0]  val;
		logic [63:0]  d;
		result_word_t w;
		stored = 1'b0;
		val = '0;
		if (m_err == ERR_NONE) begin
			case (m_phase)
				PH_START, PH_SEP: begin
					if (c != CH_NUL && !(m_phase == PH_SEP &&
							(c == CH_SPACE || c == CH_TAB || c == CH_COMMA))) begin
						if (white_char(c)) m_phase = PH_LEADWS;
						else start_number(c);
					end
				end
				PH_LEADWS: begin
					if (!white_char(c)) start_number(c);
				end
				PH_SIGN: begin
					if (c >= CH_0 && c <= CH_9) begin_digits(c);
					else m_err = ERR_NODIG;
				end
				PH_XPFX: begin
					d = char_digit(c);
					if (d < 64'd16) begin
						m_acc = d;
						m_base = BASE_HEX;
						m_phase = PH_DIGITS;
					end else begin
						// bare 0x: the number was a zero ending at the x
						m_phase = PH_SEP;
						m_err = ERR_SUFFIX;
					end
				end
				PH_ZERO: begin
					if (c == CH_LC_X || c == CH_UC_X) m_phase = PH_XPFX;
					else digit_or_close(c, stored, val);
				end
				default: digit_or_close(c, stored, val);
			endcase
		end
		w.value = stored ? val : '0;
		w.elem = stored;
		w.count = m_count;
		if (c == CH_NUL) begin
			// the terminator always reports status, possibly with the last element
			w.fin = 1'b1;
			w.ok = (m_err == ERR_NONE) && (m_count != 0);
			w.code = m_err;
			parsed_words.push_back(w);
			restart_parse();
		end else if (stored) begin
			w.fin = 1'b0;
			w.ok = 1'b0;
			w.code = ERR_NONE;
			parsed_words.push_back(w);
		end
	endtask

	// ---------------------------------------------------------------
	// idle pattern: mostly short gaps, a few long ones, and bursts with none
	// ---------------------------------------------------------------
	function automatic int unsigned pick_gap(inout int unsigned run_left);
		int unsigned r;
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			run_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// ---------------------------------------------------------------
	// character driver
	// ---------------------------------------------------------------
	int unsigned send_gap = 0;
	int unsigned send_run = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			// word taken this edge: run it through the predictor
			if (item_valid && item_ready) begin
				parse_char(character);
				chars_accepted++;
			end
			// hold a word still on offer, otherwise idle or offer the next one
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					character <= pending_chars.pop_front();
					item_valid <= 1'b1;
					send_gap = pick_gap(send_run);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor
	// ---------------------------------------------------------------
	int unsigned stall_left = 0;
	int unsigned ready_run = 0;

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			faults++;
		end
	endtask

	always @(posedge clk) begin
		result_word_t w;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (parsed_words.size() == 0) begin
					$error("result word with nothing pending");
					faults++;
				end else begin
					// oldest pending word, field by field
					w = parsed_words.pop_front();
					check_field("element_value", w.value, element_value);
					check_field("element_valid", 64'(w.elem), 64'(element_valid));
					check_field("finished", 64'(w.fin), 64'(finished));
					check_field("success", 64'(w.ok), 64'(success));
					check_field("element_count", 64'(w.count), 64'(element_count));
					check_field("error_code", 64'(w.code), 64'(error_code));
				end
				stall_left = pick_gap(ready_run);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			result_ready <= (stall_left == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic push_char(input logic [7:0] c);
		pending_chars.push_back(c);
		chars_queued++;
	endtask

	// text plus its terminator
	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i]);
		push_char(CH_NUL);
	endtask

	// one of space or tab through carriage return
	task automatic push_white();
		int unsigned r;
		r = $urandom_range(8, 13);
		push_char(r == 8 ? CH_SPACE : 8'(r));
	endtask

	task automatic push_sep();
		int unsigned r;
		r = $urandom_range(0, 2);
		push_char(r == 0 ? CH_SPACE : (r == 1 ? CH_TAB : CH_COMMA));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [COUNT_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	// only called with the parser idle between strings
	task automatic set_config(input logic [2:0] size, input logic sgn,
			input logic [COUNT_W-1:0] maxe);
		write_reg(REG_SIZE, COUNT_W'(size));
		write_reg(REG_SIGNED, COUNT_W'(sgn));
		write_reg(REG_MAX, maxe);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_size = size;
		cfg_signed = sgn;
		cfg_max = maxe;
	endtask

	// sender holds off until every byte is in and every word is out
	task automatic wait_idle();
		while (chars_accepted != chars_queued || parsed_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// one number: sign, base, digits and suffix at random, sometimes broken off
	task automatic queue_number();
		string       hexd, sfx;
		int unsigned r, kind, len;
		hexd = "0123456789abcdefABCDEF";
		sfx = "kKmMgGtT";
		r = $urandom_range(0, 9);
		if (r == 0) push_char(CH_PLUS);
		else if (r < 3) push_char(CH_MINUS);
		r = $urandom_range(0, 19);
		len = (r < 14) ? $urandom_range(1, 3) :
			(r < 18) ? $urandom_range(4, 12) : $urandom_range(13, 24);
		kind = $urandom_range(0, 15);
		if (kind < 8) begin
			// decimal
			push_char(8'(CH_0 + $urandom_range(1, 9)));
			for (int i = 1; i < len; i++) push_char(8'(CH_0 + $urandom_range(0, 9)));
		end else if (kind < 11) begin
			// octal, len - 1 digits after the zero, so a plain zero when len is 1
			push_char(CH_0);
			for (int i = 1; i < len; i++) push_char(8'(CH_0 + $urandom_range(0, 7)));
		end else if (kind < 15) begin
			// hex
			push_char(CH_0);
			push_char($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
			if (len > 17) len = 17;
			for (int i = 0; i < len; i++) push_char(hexd[$urandom_range(0, 21)]);
		end else begin
			// broken off: a bare 0x, or nothing after the sign
			if ($urandom_range(0, 1)) begin
				push_char(CH_0);
				push_char(CH_LC_X);
			end
			return;
		end
		if ($urandom_range(0, 9) >= 7) push_char(sfx[$urandom_range(0, 7)]);
	endtask

	// a list of numbers with random separators, now and then a stray byte
	task automatic queue_random_text();
		int unsigned n;
		n = $urandom_range(1, 6);
		if ($urandom_range(0, 4) == 0) push_white();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 11) == 0) push_char(8'($urandom_range(1, 255)));
			queue_number();
			if (i < n - 1) begin
				repeat ($urandom_range(1, 3)) push_sep();
				if ($urandom_range(0, 7) == 0) push_white();
			end else if ($urandom_range(0, 5) == 0) begin
				push_sep();
			end
		end
		push_char(CH_NUL);
	endtask

	task automatic random_config();
		int unsigned r;
		logic [2:0]  size;
		logic [8:0]  maxe;
		r = $urandom_range(0, 11);
		size = (r == 0) ? SZ_BYTE : (r == 1) ? SZ_HALF : (r < 6) ? SZ_WORD :
			(r < 10) ? SZ_DWORD : (r == 10) ? 3'($urandom_range(4, 7)) :
			3'($urandom_range(0, 7));
		r = $urandom_range(0, 9);
		maxe = (r == 0) ? 9'd0 : (r == 1) ? 9'd1 : (r == 2) ? 9'd3 :
			(r == 3) ? 9'($urandom_range(4, 20)) : (r < 7) ? 9'd256 :
			(r == 7) ? 9'd300 : (r == 8) ? 9'd511 : 9'($urandom_range(0, 511));
		set_config(size, 1'($urandom_range(0, 1)), maxe);
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned start_chars, phase_len;
		cfg_size = SZ_WORD;
		cfg_signed = 1'b0;
		cfg_max = 9'd256;
		restart_parse();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: 4 byte elements, unsigned, 256 max
		queue_text("");                  // empty text
		queue_text(" \t");               // white space alone
		queue_text(",1");                // leading comma
		queue_text("-");                 // sign with no digits
		queue_text("0x");                // hex prefix with no digit
		queue_text("08");                // 8 in an octal number
		queue_text("1k2");               // suffix then a new number
		queue_text("+7K,010m\n0X1fg 42");
		queue_text("-1");                // negative while unsigned
		queue_text("1q 5");              // bytes after an error are ignored
		queue_text("4294967295,4294967296");
		queue_text("0x1000000t");        // shift overflow
		queue_text("99999999999999999999999");
		wait_idle();

		// 8 byte signed: overflow clamps to all ones, which is -1 here
		set_config(SZ_DWORD, 1'b1, 9'd256);
		queue_text("99999999999999999999999,-0x8000000000000000,0xffffffffffffffff");
		queue_text("0x7fffffffffffffff 1t,-8t,0x800000t");
		wait_idle();

		// byte signed with a tiny element limit
		set_config(SZ_BYTE, 1'b1, 9'd2);
		queue_text("-128,127");
		queue_text("128");
		queue_text("1,2,3");
		wait_idle();

		// no elements allowed at all
		set_config(SZ_HALF, 1'b0, 9'd0);
		queue_text("5");
		wait_idle();

		// invalid size codes
		set_config(3'd4, 1'b0, 9'd511);
		queue_text("1");
		wait_idle();
		set_config(3'd7, 1'b1, 9'd256);
		queue_text("0x2 ");
		wait_idle();

		// random lists, fresh settings per phase, drained between phases
		start_chars = chars_queued;
		while (chars_queued - start_chars < 850) begin
			random_config();
			phase_len = chars_queued + $urandom_range(60, 160);
			while (chars_queued < phase_len) queue_random_text();
			wait_idle();
		end

		// fill to the cap of 256 and one more, limit above the cap
		set_config(SZ_BYTE, 1'b0, 9'd511);
		for (int i = 0; i < 257; i++) begin
			push_char(8'(CH_0 + $urandom_range(0, 9)));
			push_sep();
		end
		push_char(CH_NUL);
		wait_idle();

		if (faults == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ilps_pkg.sv
hdl/ilps_number_end.sv
hdl/integer_list_parser_suffix_core.sv
bench/testbench.sv
